// ===== hw/rtl/fvg_pkg.sv =====
// Shared types, constants and microcode encodings for the FAT32 volume geometry block.
`default_nettype none

package fvg_pkg;

   // Geometry constants
   localparam int unsigned SECTOR_BYTES        = 512;
   localparam int unsigned ITER_LIMIT          = 100;
   localparam int unsigned MIN_SECTORS         = 64;
   localparam int unsigned MAX_CLUSTER_BYTES   = 32768;
   localparam int unsigned CLUSTERS_LOW        = 65525;
   localparam int unsigned CLUSTERS_HIGH       = 32'h0FFF_FFF5;
   localparam int unsigned ENTRY_BYTES         = 4;
   localparam int unsigned RESERVED_DEFAULT    = 32;
   localparam int unsigned COPIES_DEFAULT      = 2;

   // Derived widths and shifts
   localparam int unsigned CAND_SHIFT_MAX = $clog2(MAX_CLUSTER_BYTES / SECTOR_BYTES);
   localparam int unsigned ENTRY_SHIFT    = $clog2(SECTOR_BYTES / ENTRY_BYTES);
   localparam int unsigned NEED_BIAS      = 2 + (SECTOR_BYTES / ENTRY_BYTES) - 1;
   localparam int unsigned TOTAL_W        = 32;
   localparam int unsigned LEN_W          = TOTAL_W + 1 - ENTRY_SHIFT;
   localparam int unsigned RES_W          = 16;
   localparam int unsigned COPIES_W       = 3;
   localparam int unsigned PROD_W         = LEN_W + COPIES_W;
   localparam int unsigned USED_W         = PROD_W + 1;
   localparam int unsigned SHIFT_W        = 3;
   localparam int unsigned ITER_W         = $clog2(ITER_LIMIT + 1);

   // Result field widths
   localparam int unsigned SPC_W   = 7;
   localparam int unsigned FATL_W  = 22;
   localparam int unsigned FDS_W   = 24;
   localparam int unsigned CLUS_W  = 28;

   // Register indexes on the configuration port
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COPIES   = 1'b1;

   // Datapath operation of one control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CLR_CAND,
      OP_INIT_LEN,
      OP_LD_USED,
      OP_LD_COUNT,
      OP_UPD_LEN,
      OP_INC_CAND,
      OP_EMIT_FAIL,
      OP_EMIT_PASS
   } op_type;

   // Jump condition of one control word
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_IDLE,
      C_TOO_FEW,
      C_NO_ROOM,
      C_AGAIN,
      C_IN_RANGE,
      C_LAST_CAND
   } cond_type;

   // Microprogram steps
   typedef enum logic [3:0] {
      S_IDLE      = 4'd0,
      S_CHK_MIN   = 4'd1,
      S_INIT_LEN  = 4'd2,
      S_CALC_USED = 4'd3,
      S_TEST_USED = 4'd4,
      S_TEST_NEED = 4'd5,
      S_RANGE     = 4'd6,
      S_NEXT_CAND = 4'd7,
      S_LOOP      = 4'd8,
      S_FAIL      = 4'd9,
      S_SUM       = 4'd10,
      S_PASS      = 4'd11
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic too_few;
      logic no_room;
      logic again;
      logic in_range;
      logic last_cand;
   } flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fvg_ctrl_rom.sv =====
// Control store: one control word per microprogram step.
`default_nettype none

module fvg_ctrl_rom (
   input  fvg_pkg::step_type step,
   output fvg_pkg::ctrl_type ctrl
);
   import fvg_pkg::*;

   // Decode the step into operation, jump condition and jump target
   always_comb begin
      case (step)
         S_IDLE:      ctrl = '{op: OP_LOAD,      cond: C_IDLE,      target: S_IDLE};
         S_CHK_MIN:   ctrl = '{op: OP_CLR_CAND,  cond: C_TOO_FEW,   target: S_FAIL};
         S_INIT_LEN:  ctrl = '{op: OP_INIT_LEN,  cond: C_NEVER,     target: S_IDLE};
         S_CALC_USED: ctrl = '{op: OP_LD_USED,   cond: C_NEVER,     target: S_IDLE};
         S_TEST_USED: ctrl = '{op: OP_LD_COUNT,  cond: C_NO_ROOM,   target: S_NEXT_CAND};
         S_TEST_NEED: ctrl = '{op: OP_UPD_LEN,   cond: C_AGAIN,     target: S_CALC_USED};
         S_RANGE:     ctrl = '{op: OP_NOP,       cond: C_IN_RANGE,  target: S_SUM};
         S_NEXT_CAND: ctrl = '{op: OP_INC_CAND,  cond: C_LAST_CAND, target: S_FAIL};
         S_LOOP:      ctrl = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_INIT_LEN};
         S_FAIL:      ctrl = '{op: OP_EMIT_FAIL, cond: C_ALWAYS,    target: S_IDLE};
         S_SUM:       ctrl = '{op: OP_LD_USED,   cond: C_NEVER,     target: S_IDLE};
         S_PASS:      ctrl = '{op: OP_EMIT_PASS, cond: C_ALWAYS,    target: S_IDLE};
         default:     ctrl = '{op: OP_NOP,       cond: C_ALWAYS,    target: S_IDLE};
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fvg_datapath.sv =====
// Datapath: configuration registers, working registers, flags and result registers.
`default_nettype none

module fvg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fvg_pkg::op_type                     op,
   input  logic [fvg_pkg::TOTAL_W-1:0]         req_total_sectors,
   input  logic                                csr_write,
   input  logic [fvg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fvg_pkg::RES_W-1:0]           csr_data,
   output fvg_pkg::flags_type                  flags,
   output logic                                rsp_strobe,
   output logic                                rsp_status,
   output logic [fvg_pkg::SPC_W-1:0]           rsp_cluster_size,
   output logic [fvg_pkg::FATL_W-1:0]          rsp_fat_length,
   output logic [fvg_pkg::FDS_W-1:0]           rsp_first_data_sector,
   output logic [fvg_pkg::CLUS_W-1:0]          rsp_cluster_total
);
   import fvg_pkg::*;

   logic [RES_W-1:0]    reserved_ff, reserved_in;
   logic [COPIES_W-1:0] copies_ff, copies_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [TOTAL_W-1:0]  count_ff, count_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                strobe_ff, strobe_in;
   logic                status_ff, status_in;
   logic [SPC_W-1:0]    spc_ff, spc_in;
   logic [FATL_W-1:0]   fatl_ff, fatl_in;
   logic [FDS_W-1:0]    fds_ff, fds_in;
   logic [CLUS_W-1:0]   clus_ff, clus_in;

   logic [PROD_W-1:0]   fat_prod;
   logic [USED_W-1:0]   used_sum;
   logic [TOTAL_W-1:0]  used_wide;
   logic [TOTAL_W-1:0]  free_sectors;
   logic [TOTAL_W:0]    need_sum;
   logic [LEN_W-1:0]    need;
   logic                covers;
   logic                iter_last;

   // Sectors taken by reserved area and all FAT copies
   assign fat_prod  = {{(PROD_W-COPIES_W){1'b0}}, copies_ff} * {{COPIES_W{1'b0}}, len_ff};
   assign used_sum  = {{(USED_W-RES_W){1'b0}}, reserved_ff} + {1'b0, fat_prod};
   assign used_wide = {{(TOTAL_W-USED_W){1'b0}}, used_ff};

   // Sectors left after the reserved area and FATs, and FAT sectors the cluster count needs
   assign free_sectors = total_ff - used_wide;
   assign need_sum     = {1'b0, count_ff} + (TOTAL_W+1)'(NEED_BIAS);
   assign need         = need_sum[TOTAL_W:ENTRY_SHIFT];
   assign covers       = len_ff >= need;
   assign iter_last    = iter_ff == ITER_W'(ITER_LIMIT - 1);

   // Flags for the sequencer's jump conditions
   assign flags.too_few   = total_ff < TOTAL_W'(MIN_SECTORS);
   assign flags.no_room   = used_wide >= total_ff;
   assign flags.again     = !covers && !iter_last;
   assign flags.in_range  = (count_ff >= TOTAL_W'(CLUSTERS_LOW)) &&
                            (count_ff <= TOTAL_W'(CLUSTERS_HIGH));
   assign flags.last_cand = shift_ff == SHIFT_W'(CAND_SHIFT_MAX);

   // Next values: hold unless the current operation or a config transfer says otherwise
   always_comb begin
      reserved_in = reserved_ff;
      copies_in   = copies_ff;
      total_in    = total_ff;
      shift_in    = shift_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      iter_in     = iter_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      spc_in      = spc_ff;
      fatl_in     = fatl_ff;
      fds_in      = fds_ff;
      clus_in     = clus_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_RESERVED: reserved_in = csr_data;
            CSR_COPIES:   copies_in   = csr_data[COPIES_W-1:0];
            default:      reserved_in = reserved_ff;
         endcase
      end

      case (op)
         OP_LOAD:     total_in = req_total_sectors;
         OP_CLR_CAND: shift_in = '0;
         OP_INIT_LEN: begin
            len_in   = LEN_W'(1);
            count_in = '0;
            iter_in  = '0;
         end
         OP_LD_USED:  used_in  = used_sum;
         OP_LD_COUNT: count_in = free_sectors >> shift_ff;
         OP_UPD_LEN: begin
            if (!covers) begin
               len_in  = need;
               iter_in = iter_ff + ITER_W'(1);
            end
         end
         OP_INC_CAND: shift_in = shift_ff + SHIFT_W'(1);
         OP_EMIT_FAIL: begin
            strobe_in = 1'b1;
            status_in = 1'b1;
            spc_in    = '0;
            fatl_in   = '0;
            fds_in    = '0;
            clus_in   = '0;
         end
         OP_EMIT_PASS: begin
            strobe_in = 1'b1;
            status_in = 1'b0;
            spc_in    = SPC_W'(1) << shift_ff;
            fatl_in   = len_ff[FATL_W-1:0];
            fds_in    = used_ff[FDS_W-1:0];
            clus_in   = count_ff[CLUS_W-1:0];
         end
         default: strobe_in = 1'b0;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= RES_W'(RESERVED_DEFAULT);
         copies_ff   <= COPIES_W'(COPIES_DEFAULT);
         strobe_ff   <= 1'b0;
      end else begin
         reserved_ff <= reserved_in;
         copies_ff   <= copies_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      total_ff <= total_in;
      shift_ff <= shift_in;
      len_ff   <= len_in;
      count_ff <= count_in;
      used_ff  <= used_in;
      iter_ff  <= iter_in;
      status_ff <= status_in;
      spc_ff   <= spc_in;
      fatl_ff  <= fatl_in;
      fds_ff   <= fds_in;
      clus_ff  <= clus_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_cluster_size      = spc_ff;
   assign rsp_fat_length        = fatl_ff;
   assign rsp_first_data_sector = fds_ff;
   assign rsp_cluster_total     = clus_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fat32_volume_geometry.sv =====
// A volume under 64 sectors fails without a search; otherwise up to seven cluster sizes are
// tried, each with up to 100 FAT length refinements.
// Each FAT length refinement takes 3 microprogram steps (FAT size, cluster count, cover test).
// Throughput: one volume at a time; busy is high from the start transfer until the result.
// Reset (synchronous, active high): sequencer idle, no strobe, reserved 32, FAT copies 2.
// The result strobe lasts one cycle and cannot be held off.
`default_nettype none

module fat32_volume_geometry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [fvg_pkg::TOTAL_W-1:0]       req_total_sectors,
   output logic                              rsp_strobe,
   output logic                              rsp_status,
   output logic [fvg_pkg::SPC_W-1:0]         rsp_cluster_size,
   output logic [fvg_pkg::FATL_W-1:0]        rsp_fat_length,
   output logic [fvg_pkg::FDS_W-1:0]         rsp_first_data_sector,
   output logic [fvg_pkg::CLUS_W-1:0]        rsp_cluster_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fvg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fvg_pkg::RES_W-1:0]         csr_data
);
   import fvg_pkg::*;

   step_type  pc_ff, pc_in;
   ctrl_type  ctrl;
   flags_type flags;
   logic      jump;

   fvg_ctrl_rom u_rom (
      .step (pc_ff),
      .ctrl (ctrl)
   );

   fvg_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .op                    (ctrl.op),
      .req_total_sectors     (req_total_sectors),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .flags                 (flags),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_cluster_size      (rsp_cluster_size),
      .rsp_fat_length        (rsp_fat_length),
      .rsp_first_data_sector (rsp_first_data_sector),
      .rsp_cluster_total     (rsp_cluster_total)
   );

   // Take configuration transfers only while idle and no volume is being started
   assign csr_ready = !busy && !start;
   assign busy      = pc_ff != S_IDLE;

   // Advance the step counter, or jump when the selected condition holds
   always_comb begin
      case (ctrl.cond)
         C_NEVER:     jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_IDLE:      jump = !start;
         C_TOO_FEW:   jump = flags.too_few;
         C_NO_ROOM:   jump = flags.no_room;
         C_AGAIN:     jump = flags.again;
         C_IN_RANGE:  jump = flags.in_range;
         C_LAST_CAND: jump = flags.last_cand;
         default:     jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : step_type'(4'(pc_ff) + 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   // A strobe only follows one of the two result steps
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(pc_ff) == S_FAIL || $past(pc_ff) == S_PASS))
      else $error("result strobe without a result step");

   // A failed layout reports all fields as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_cluster_size == '0 &&
         rsp_fat_length == '0 && rsp_first_data_sector == '0 && rsp_cluster_total == '0))
      else $error("failed layout with nonzero fields");

   // A found layout has a power-of-two cluster size and a count of at least 65525
   a_pass_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_status) |-> ($onehot(rsp_cluster_size) &&
         rsp_cluster_total >= CLUS_W'(CLUSTERS_LOW)))
      else $error("found layout out of range");

   // A start transfer makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer not taken");
`endif

endmodule

`default_nettype wire
